// ===== src/fir_hilbert_or_derivative_filter_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the antisymmetric FIR filter
// Shared property forms for same-cycle and next-cycle checks.
// ---------------------------------------------------------------------------
`ifndef FIR_HILBERT_OR_DERIVATIVE_FILTER_ASSERT_SVH
`define FIR_HILBERT_OR_DERIVATIVE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fhd_pkg.sv =====
// ---------------------------------------------------------------------------
// fhd_pkg
// Constants, controller/datapath link types and the coefficient functions
// used to build the Hilbert and derivative coefficient tables.
// ---------------------------------------------------------------------------
package fhd_pkg;

    // Coefficient format: signed Q1.17.
    localparam int COEF_BITS = 18;
    localparam int COEF_FRAC = 17;

    // Fixed-point constants in Q30.
    localparam longint unsigned PI_Q30          = 64'd3373259426;
    localparam longint unsigned TWO_OVER_PI_Q30 = 64'd683565276;
    localparam longint unsigned ONE_Q30         = 64'd1073741824;

    // Mode register codes.
    localparam logic [1:0] MODE_HILBERT    = 2'd0;
    localparam logic [1:0] MODE_DERIVATIVE = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic issue;
        logic load;
    } fhd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } fhd_status_t;

    // Restoring long division, evaluated only while the tables are built.
    function automatic longint unsigned fhd_udiv(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos(pi * m / h) in Q30 by a folded Taylor series, for 0 <= m <= h.
    function automatic longint fhd_cos_q30(input longint unsigned m,
                                           input longint unsigned h);
        logic            neg;
        longint unsigned mm;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        neg = 1'b0;
        mm  = m;
        if (2 * m > h)
        begin
            neg = 1'b1;
            mm  = h - m;
        end
        x   = fhd_udiv(PI_Q30 * mm + (h >> 1), h);
        x2  = (x * x + (64'd1 << 29)) >> 30;
        t   = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int n = 1; n <= 7; n++)
        begin
            t = fhd_udiv((t * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
            if (n[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        return neg ? -sum : sum;
    endfunction

    // Hamming window 0.54 + 0.46 cos(pi k / half) in Q30.
    function automatic longint unsigned fhd_window(input int k, input int half);
        longint c;
        c = fhd_cos_q30(longint'(k), longint'(half));
        return longint'((54 * longint'(ONE_Q30) + 46 * c + 50) / 100);
    endfunction

    // Hilbert coefficient for tap offset k: windowed 2/(pi k) on odd offsets.
    function automatic logic signed [COEF_BITS-1:0] fhd_hil_coef(input int k,
                                                                 input int half,
                                                                 input int taps);
        longint unsigned w;
        longint unsigned den;
        longint unsigned v;
        v = '0;
        if (k[0] && ((k + 1) / 2 <= taps / 4))
        begin
            w   = fhd_window(k, half);
            den = longint'(k) << 43;
            v   = fhd_udiv(w * TWO_OVER_PI_Q30 + (den >> 1), den);
        end
        return COEF_BITS'(v);
    endfunction

    // Derivative coefficient for tap offset k: windowed cos(pi k) / k.
    function automatic logic signed [COEF_BITS-1:0] fhd_der_coef(input int k,
                                                                 input int half);
        longint unsigned            w;
        longint unsigned            den;
        logic signed [COEF_BITS-1:0] c;
        w   = fhd_window(k, half);
        den = longint'(k) << 13;
        c   = COEF_BITS'(fhd_udiv(w + (den >> 1), den));
        if (k[0])
            c = -c;
        return c;
    endfunction

endpackage

// ===== src/fhd_if.sv =====
// ---------------------------------------------------------------------------
// fhd_if
// Valid/ready channels carrying sample words in and filtered words out.
// ---------------------------------------------------------------------------

// Sample channel: one input sample and its record-start flag per word.
interface fhd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          new_record;

    modport source (output valid, output sample, output new_record, input ready);
    modport sink   (input valid, input sample, input new_record, output ready);
endinterface

// Result channel: one filtered sample and its warm-up flag per word.
interface fhd_result_if #(
    parameter int RESULT_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic signed [RESULT_BITS-1:0] filtered;
    logic                          warm_up;

    modport source (output valid, output filtered, output warm_up, input ready);
    modport sink   (input valid, input filtered, input warm_up, output ready);
endinterface

// ===== src/fir_hilbert_or_derivative_filter.sv =====
// ---------------------------------------------------------------------------
// fir_hilbert_or_derivative_filter
// Antisymmetric FIR filter, Hilbert transformer or differentiator, built as
// a sequencer driving a shared multiply-accumulate datapath.
// ---------------------------------------------------------------------------
// Usage:
// Samples arrive on the valid/ready channel "samples"; each word carries one
// signed sample and a flag that starts a new record and empties the history.
// Filtered samples leave on "results", one word per input word, saturated to
// SAMPLE_BITS+4 bits, with a flag on the first (TAPS-1)/2 words of a record.
// The mode register (cfg_wr_en, cfg_wr_data) picks Hilbert (0), derivative
// (1) or zero coefficients; the user must write it only while the block is
// idle, and the block itself does not enforce this. Each accepted word is
// stepped through its (TAPS-1)/2 tap pairs, the pipeline is drained and the
// result is rounded and loaded into the output register; the next word is
// taken once the block is idle again, so one word is in work at a time. The
// single multiply-accumulate unit takes one tap pair per cycle from the two
// read ports of the history memory and feeds a four-stage pipeline.
// Reset selects the Hilbert set and treats the history as empty, as for a
// record start. The result sits in an output register: a new sample is taken
// while it waits, but the next result is held back until it is taken.
// ---------------------------------------------------------------------------
module fir_hilbert_or_derivative_filter
    import fhd_pkg::*;
#(
    parameter int TAPS        = 201,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    fhd_sample_if.sink   samples,
    fhd_result_if.source results
);

    localparam int OUT_BITS = SAMPLE_BITS + 4;

    fhd_cmd_t    cmd;
    fhd_status_t status;

    // Sequencer.
    fhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // History, coefficients and multiply-accumulate.
    fhd_datapath #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (samples.sample),
        .new_record  (samples.new_record),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .filtered    (results.filtered),
        .warm_up     (results.warm_up)
    );

endmodule

// ===== src/fhd_ctrl.sv =====
// ---------------------------------------------------------------------------
// fhd_ctrl
// Sequencer: takes a word, steps the datapath through the tap pairs,
// waits for the pipeline to drain and hands the result to the output.
// ---------------------------------------------------------------------------
module fhd_ctrl
    import fhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fhd_status_t status,
    output fhd_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Ready only between items.
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/fhd_datapath.sv =====
// ---------------------------------------------------------------------------
// fhd_datapath
// Sample history memory, tap-pair address walkers, coefficient tables and
// the shared multiply-accumulate pipeline with rounding and saturation.
// ---------------------------------------------------------------------------
module fhd_datapath
    import fhd_pkg::*;
#(
    parameter int TAPS        = 201,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fhd_cmd_t                        cmd,
    output fhd_status_t                     status,
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_wr_data,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            new_record,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic signed [SAMPLE_BITS+3:0]   filtered,
    output logic                            warm_up
);

    localparam int HALF      = (TAPS - 1) / 2;
    localparam int OUT_BITS  = SAMPLE_BITS + 4;
    localparam int ADDR_BITS = $clog2(TAPS);
    localparam int WIDE_BITS = ADDR_BITS + 1;
    localparam int CNT_BITS  = $clog2(TAPS + 1);
    localparam int K_BITS    = $clog2(HALF);
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(HALF) + 1;
    localparam int Q_BITS    = ACC_BITS - COEF_FRAC;

    localparam logic [ACC_BITS-1:0] ROUND_C =
        {{(ACC_BITS - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};

    // History memory and its bookkeeping.
    logic signed [SAMPLE_BITS-1:0] hist_mem [TAPS];
    logic [ADDR_BITS-1:0]          wp_reg;
    logic [CNT_BITS-1:0]           fill_reg;
    logic                          warm_reg;
    logic [1:0]                    mode_reg;

    // Address walkers and tap counter.
    logic [ADDR_BITS-1:0] addr_a_reg;
    logic [ADDR_BITS-1:0] addr_b_reg;
    logic [K_BITS-1:0]    k_reg;

    // Pipeline stages.
    logic                          vld1_reg;
    logic                          vld2_reg;
    logic                          vld3_reg;
    logic signed [SAMPLE_BITS-1:0] rd_a_reg;
    logic signed [SAMPLE_BITS-1:0] rd_b_reg;
    logic                          va1_reg;
    logic                          vb1_reg;
    logic [K_BITS-1:0]             k1_reg;
    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [COEF_BITS-1:0]   coef_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [OUT_BITS-1:0]  filtered_reg;
    logic                        warm_up_reg;

    // Combinational helpers.
    logic [ADDR_BITS-1:0]        wp_eff;
    logic [WIDE_BITS-1:0]        wp_wide;
    logic [CNT_BITS-1:0]         fill_base;
    logic [ADDR_BITS-1:0]        wp_next;
    logic [CNT_BITS-1:0]         fill_next;
    logic [WIDE_BITS-1:0]        a_start;
    logic [WIDE_BITS-1:0]        b_start;
    logic signed [SAMPLE_BITS-1:0] da;
    logic signed [SAMPLE_BITS-1:0] db;
    logic signed [DIFF_BITS-1:0] diff_next;
    logic signed [COEF_BITS-1:0] coef_next;
    logic signed [PROD_BITS-1:0] prod_next;
    logic [ACC_BITS-1:0]         rnd;
    logic [Q_BITS-1:0]           q;
    logic [Q_BITS-OUT_BITS:0]    q_upper;
    logic signed [OUT_BITS-1:0]  sat;

    // Coefficient tables, one entry per tap offset 1..HALF.
    logic signed [COEF_BITS-1:0] hil_rom [HALF];
    logic signed [COEF_BITS-1:0] der_rom [HALF];

    for (genvar gk = 0; gk < HALF; gk++)
    begin : g_rom
        localparam logic signed [COEF_BITS-1:0] HIL_C = fhd_hil_coef(gk + 1, HALF, TAPS);
        localparam logic signed [COEF_BITS-1:0] DER_C = fhd_der_coef(gk + 1, HALF);
        assign hil_rom[gk] = HIL_C;
        assign der_rom[gk] = DER_C;
    end

    // A record start places its sample at entry zero with an empty history.
    assign wp_eff    = new_record ? '0 : wp_reg;
    assign wp_wide   = {1'b0, wp_eff};
    assign fill_base = new_record ? '0 : fill_reg;
    assign wp_next   = (wp_eff == ADDR_BITS'(TAPS - 1)) ? '0 : wp_eff + 1'b1;
    assign fill_next = (fill_base == CNT_BITS'(TAPS)) ? fill_base : fill_base + 1'b1;

    // First tap pair: offsets HALF+1 and HALF-1 behind the new sample.
    assign a_start = (wp_wide >= WIDE_BITS'(HALF + 1)) ? wp_wide - WIDE_BITS'(HALF + 1)
                                                       : wp_wide + WIDE_BITS'(TAPS - HALF - 1);
    assign b_start = (wp_wide >= WIDE_BITS'(HALF - 1)) ? wp_wide - WIDE_BITS'(HALF - 1)
                                                       : wp_wide + WIDE_BITS'(TAPS - HALF + 1);

    // Pre-subtraction; entries not yet written in this record count as zero.
    assign da        = va1_reg ? rd_a_reg : '0;
    assign db        = vb1_reg ? rd_b_reg : '0;
    assign diff_next = {da[SAMPLE_BITS-1], da} - {db[SAMPLE_BITS-1], db};

    // Coefficient selection by mode; unknown modes give zero.
    always_comb
    begin
        case (mode_reg)
            MODE_HILBERT:    coef_next = hil_rom[k1_reg];
            MODE_DERIVATIVE: coef_next = der_rom[k1_reg];
            default:         coef_next = '0;
        endcase
    end

    assign prod_next = diff_reg * coef_reg;

    // Round half up, drop the fraction, then saturate to the output width.
    assign rnd     = acc_reg + ROUND_C;
    assign q       = rnd[ACC_BITS-1:COEF_FRAC];
    assign q_upper = q[Q_BITS-1:OUT_BITS-1];

    always_comb
    begin
        if ((&q_upper) || !(|q_upper))
            sat = q[OUT_BITS-1:0];
        else if (q[Q_BITS-1])
            sat = {1'b1, {(OUT_BITS - 1){1'b0}}};
        else
            sat = {1'b0, {(OUT_BITS - 1){1'b1}}};
    end

    // Status towards the controller.
    assign status.last_issue = (k_reg == K_BITS'(HALF - 1));
    assign status.pipe_busy  = vld1_reg || vld2_reg || vld3_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign warm_up   = warm_up_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            mode_reg      <= MODE_HILBERT;
            k_reg         <= '0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (cmd.start)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
                k_reg    <= '0;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            vld1_reg <= cmd.issue;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // History memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            hist_mem[wp_eff] <= sample;
        if (cmd.issue)
        begin
            rd_a_reg <= hist_mem[addr_a_reg];
            rd_b_reg <= hist_mem[addr_b_reg];
        end
    end

    // Address walkers and the multiply-accumulate pipeline.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            addr_a_reg <= a_start[ADDR_BITS-1:0];
            addr_b_reg <= b_start[ADDR_BITS-1:0];
            warm_reg   <= (fill_base < CNT_BITS'(HALF));
            acc_reg    <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                addr_a_reg <= (addr_a_reg == '0) ? ADDR_BITS'(TAPS - 1) : addr_a_reg - 1'b1;
                addr_b_reg <= (addr_b_reg == ADDR_BITS'(TAPS - 1)) ? '0 : addr_b_reg + 1'b1;
            end
            if (vld3_reg)
                acc_reg <= acc_reg + {{(ACC_BITS - PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
        end
        va1_reg  <= (CNT_BITS'(addr_a_reg) < fill_reg);
        vb1_reg  <= (CNT_BITS'(addr_b_reg) < fill_reg);
        k1_reg   <= k_reg;
        diff_reg <= diff_next;
        coef_reg <= coef_next;
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            filtered_reg <= sat;
            warm_up_reg  <= warm_reg;
        end
    end

endmodule

// ===== src/fhd_checker.sv =====
// ---------------------------------------------------------------------------
// fhd_checker
// Port-level checks on the filter's handshakes and its one-word-at-a-time
// sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`include "fir_hilbert_or_derivative_filter_assert.svh"

module fhd_checker #(
    parameter int OUT_BITS = 20
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [OUT_BITS-1:0] filtered,
    input logic                warm_up
);

    // A stalled result word must stay put.
    `FHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(filtered) && $stable(warm_up), "result word changed while stalled")

    // Once a word is taken the block is busy with it.
    `FHD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input ready straight after an accepted word")

    // An idle block with no offered word stays idle.
    `FHD_ASSERT_NEXT(a_idle_holds, clk, rst_n, in_ready && !in_valid, in_ready, "input ready dropped without a word")

    // A new result appears only as the block finishes a word.
    `FHD_ASSERT_NOW(a_result_ends_work, clk, rst_n, $rose(out_valid), in_ready && $past(!in_ready), "result shown outside the end of a word")

endmodule

bind fir_hilbert_or_derivative_filter fhd_checker #(
    .OUT_BITS (OUT_BITS)
) u_fhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .filtered  (results.filtered),
    .warm_up   (results.warm_up)
);
